// ----- design/spe_pkg.sv -----
// Shared types, widths and codes of the cubic spline point evaluator.
// Used by the channel interfaces and by every module of the block but spe_ram.
`default_nettype none

package spe_pkg;

  localparam int COORD_W  = 32;
  localparam int PARAM_W  = 17;
  localparam int FRAC_W   = 16;
  localparam int CNT_W    = 7;
  localparam int KIND_W   = 2;
  localparam int TENS_W   = 19;
  localparam int OP_W     = 2;
  localparam int PIDX_W   = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 19;

  // Derived arithmetic widths.
  localparam int SCALED_W = PARAM_W + CNT_W;
  localparam int SQ_W     = 2 * PARAM_W;
  localparam int CUBE_W   = 3 * FRAC_W + 1;
  localparam int ACC_W    = 52;
  localparam int A_W      = 31;
  localparam int Q_W      = 19;
  localparam int S_W      = 20;
  localparam int SP_W     = 52;
  localparam int BP_W     = 37;
  localparam int WGT_W    = 20;
  localparam int PROD_W   = COORD_W + WGT_W;
  localparam int SUM_W    = PROD_W + 2;

  localparam logic [PARAM_W-1:0] ONE_Q16  = 17'h10000;
  localparam logic [17:0]        DIV6_MUL = 18'd174763;

  localparam logic [OP_W-1:0] OP_WR_POS  = 2'd0;
  localparam logic [OP_W-1:0] OP_WR_TIN  = 2'd1;
  localparam logic [OP_W-1:0] OP_WR_TOUT = 2'd2;
  localparam logic [OP_W-1:0] OP_EVAL    = 2'd3;

  localparam logic [KIND_W-1:0] KIND_LINEAR  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_BEZIER  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CATMULL = 2'd2;
  localparam logic [KIND_W-1:0] KIND_BSPLINE = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_KIND    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CLOSED  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TENSION = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT   = 2'd3;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [2:0][COORD_W-1:0] vec3_t;
  typedef logic signed [WGT_W-1:0] wgt_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              closed;
    logic [TENS_W-1:0] tension;
    logic [CNT_W-1:0]  count;
  } cfg_t;

endpackage

`default_nettype wire

// ----- design/spe_in_if.sv -----
// Input channel of the spline evaluator: valid/ready plus one command item.
// Depends on spe_pkg for the field widths.
`default_nettype none

interface spe_in_if
  import spe_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     op;
  logic [PIDX_W-1:0]   point_index;
  logic [COORD_W-1:0]  vec_x;
  logic [COORD_W-1:0]  vec_y;
  logic [COORD_W-1:0]  vec_z;
  logic [PARAM_W-1:0]  eval_param;

  modport source (output valid, op, point_index, vec_x, vec_y, vec_z, eval_param,
                  input ready);
  modport sink (input valid, op, point_index, vec_x, vec_y, vec_z, eval_param,
                output ready);
endinterface

`default_nettype wire

// ----- design/spe_out_if.sv -----
// Output channel of the spline evaluator: valid/ready plus one curve point.
// Depends on spe_pkg for the field widths.
`default_nettype none

interface spe_out_if
  import spe_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] curve_x;
  logic [COORD_W-1:0] curve_y;
  logic [COORD_W-1:0] curve_z;

  modport source (output valid, curve_x, curve_y, curve_z, input ready);
  modport sink (input valid, curve_x, curve_y, curve_z, output ready);
endinterface

`default_nettype wire

// ----- design/spe_ram.sv -----
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none

module spe_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

`default_nettype wire

// ----- design/spe_seg.sv -----
// Segment selection: scales the parameter by the segment count, clamps the
// end and forms the four neighbor indices. Depends on spe_pkg.
`default_nettype none

module spe_seg
  import spe_pkg::*;
#(
  parameter int MAX_POINTS = 64,
  localparam int IDX_W = $clog2(MAX_POINTS)
) (
  input  logic                   clk_i,
  input  logic                   en_i,
  input  cfg_t                   cfg_i,
  input  logic [PARAM_W-1:0]     param_i,
  output logic [PARAM_W-1:0]     u_o,
  output logic [KIND_W-1:0]      kind_o,
  output logic                   zero_o,
  output logic [CNT_W-1:0]       n_o,
  output logic [3:0][IDX_W-1:0]  idx_o
);
  logic [CNT_W-1:0]          n, nseg, seg_d, seg_q, n_q;
  logic [SCALED_W-1:0]       scaled;
  logic [SCALED_W-FRAC_W-1:0] seg_raw;
  logic [PARAM_W-1:0]        u_d, u_q;
  logic [KIND_W-1:0]         kind_d, kind_q;
  logic                      zero_d, zero_q, closed_q;
  logic [CNT_W:0]            s1, s2, s2w, nn;
  logic [CNT_W-1:0]          i0, i1, i2, i3;

  always_comb begin
    n = (int'(cfg_i.count) > MAX_POINTS) ? CNT_W'(MAX_POINTS) : cfg_i.count;
    nseg = cfg_i.closed ? n : n - CNT_W'(1);
    scaled = SCALED_W'(param_i) * SCALED_W'(nseg);
    seg_raw = scaled[SCALED_W-1:FRAC_W];
    kind_d = cfg_i.kind;
    zero_d = 1'b0;
    if (seg_raw >= {1'b0, nseg}) begin
      seg_d = nseg - CNT_W'(1);
      u_d = ONE_Q16;
    end else begin
      seg_d = seg_raw[CNT_W-1:0];
      u_d = {1'b0, scaled[FRAC_W-1:0]};
    end
    // With one point, a linear blend at u = 0 returns point 0; with none, the result is zero.
    if (n < CNT_W'(2)) begin
      seg_d = '0;
      u_d = '0;
      kind_d = KIND_LINEAR;
      zero_d = (n == '0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      seg_q <= seg_d;
      u_q <= u_d;
      kind_q <= kind_d;
      zero_q <= zero_d;
      n_q <= n;
      closed_q <= cfg_i.closed;
    end
  end

  always_comb begin
    nn = {1'b0, n_q};
    s1 = {1'b0, seg_q} + (CNT_W+1)'(1);
    s2 = {1'b0, seg_q} + (CNT_W+1)'(2);
    s2w = s2 - nn;
    i1 = seg_q;
    i2 = (s1 == nn) ? '0 : s1[CNT_W-1:0];
    if (closed_q) begin
      i0 = (seg_q == '0) ? n_q - CNT_W'(1) : seg_q - CNT_W'(1);
      i3 = (s2 >= nn) ? s2w[CNT_W-1:0] : s2[CNT_W-1:0];
    end else begin
      i0 = (seg_q == '0) ? '0 : seg_q - CNT_W'(1);
      i3 = (s2 < nn) ? s2[CNT_W-1:0] : n_q - CNT_W'(1);
    end
    idx_o[0] = IDX_W'(i0);
    idx_o[1] = IDX_W'(i1);
    idx_o[2] = IDX_W'(i2);
    idx_o[3] = IDX_W'(i3);
  end

  assign u_o = u_q;
  assign kind_o = kind_q;
  assign zero_o = zero_q;
  assign n_o = n_q;
endmodule

`default_nettype wire

// ----- design/spe_weights.sv -----
// Five-stage pipeline that turns the local parameter u into the four basis
// weights of the selected curve kind. Depends on spe_pkg.
`default_nettype none

module spe_weights
  import spe_pkg::*;
(
  input  logic               clk_i,
  input  logic               en_i,
  input  logic [PARAM_W-1:0] u_i,
  input  logic [KIND_W-1:0]  kind_i,
  input  logic [TENS_W-1:0]  tension_i,
  output wgt_t [3:0]         w_o,
  output logic [KIND_W-1:0]  kind_o
);
  localparam logic [ACC_W-1:0] RND_16 = ACC_W'(1) << 15;
  localparam logic [ACC_W-1:0] RND_32 = ACC_W'(1) << 31;
  localparam logic [ACC_W-1:0] RND_6  = ACC_W'(3) << 32;
  localparam logic [ACC_W-1:0] ONE_48 = ACC_W'(1) << 48;
  localparam logic [ACC_W-1:0] FOUR_48 = ACC_W'(1) << 50;
  localparam logic signed [SP_W-1:0] RND_33 = SP_W'(1) << 32;
  localparam logic signed [WGT_W-1:0] ONE_W = WGT_W'(65536);

  // Stage 2: squares.
  logic [PARAM_W-1:0] v1, u2_q, v2_q;
  logic [SQ_W-1:0]    uu2_q, uv2_q, vv2_q;
  logic [KIND_W-1:0]  kind2_q;
  // Stage 3: cubes.
  logic [CUBE_W-1:0]  cu3_q, cv3_q, uvv3_q, uuv3_q;
  logic [SQ_W-1:0]    uu3_q;
  logic [PARAM_W-1:0] u3_q, v3_q;
  logic [KIND_W-1:0]  kind3_q;
  // Stage 4: rounded terms.
  logic [ACC_W-1:0]   cu, cv, uvv, uuv, uu, uw;
  logic [ACC_W-1:0]   t_bz0, t_bz1, t_bz2, t_bz3, t_a, t_b, t_h, n0, n1, n2, n3;
  logic [3:0][PARAM_W-1:0] bz4_q, bz5_q;
  logic [A_W-1:0]     a4_q, b4_q;
  logic [PARAM_W-1:0] h4_q, h5_q, u4_q, v4_q, u5_q, v5_q;
  logic [3:0][Q_W-1:0] q4_q;
  logic [KIND_W-1:0]  kind4_q, kind5_q, kind6_q;
  // Stage 5: tension and divide-by-six products.
  logic signed [S_W-1:0]  s17;
  logic signed [SP_W-1:0] sa5_q, sb5_q, ta, tb;
  logic [3:0][BP_W-1:0]   bp5_q;
  // Stage 6: final weights.
  wgt_t [3:0]  w6_d, w6_q;
  wgt_t        sa_w, sb_w, h_w;

  assign v1 = ONE_Q16 - u_i;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      u2_q <= u_i;
      v2_q <= v1;
      uu2_q <= SQ_W'(u_i) * SQ_W'(u_i);
      uv2_q <= SQ_W'(u_i) * SQ_W'(v1);
      vv2_q <= SQ_W'(v1) * SQ_W'(v1);
      kind2_q <= kind_i;

      cu3_q <= CUBE_W'(uu2_q) * CUBE_W'(u2_q);
      cv3_q <= CUBE_W'(vv2_q) * CUBE_W'(v2_q);
      uvv3_q <= CUBE_W'(uv2_q) * CUBE_W'(v2_q);
      uuv3_q <= CUBE_W'(uu2_q) * CUBE_W'(v2_q);
      uu3_q <= uu2_q;
      u3_q <= u2_q;
      v3_q <= v2_q;
      kind3_q <= kind2_q;
    end
  end

  always_comb begin
    cu = ACC_W'(cu3_q);
    cv = ACC_W'(cv3_q);
    uvv = ACC_W'(uvv3_q);
    uuv = ACC_W'(uuv3_q);
    uu = ACC_W'(uu3_q);
    uw = ACC_W'(u3_q);
    t_bz0 = cv + RND_32;
    t_bz1 = (uvv << 1) + uvv + RND_32;
    t_bz2 = (uuv << 1) + uuv + RND_32;
    t_bz3 = cu + RND_32;
    t_a = uvv + RND_16;
    t_b = uuv + RND_16;
    // u^2 * (3 - 2u) in Q48, rounded to Q16.
    t_h = (uu << 17) + (uu << 16) - (cu << 1) + RND_32;
    // B-spline numerators in Q48, plus half of the 6 * 2^32 divisor.
    n0 = cv + RND_6;
    n1 = (cu << 1) + cu + FOUR_48 - (uu << 18) - (uu << 17) + RND_6;
    n2 = (uu << 17) + (uu << 16) + (uw << 33) + (uw << 32) + ONE_48
         - (cu << 1) - cu + RND_6;
    n3 = cu + RND_6;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      bz4_q[0] <= t_bz0[CUBE_W-1:2*FRAC_W];
      bz4_q[1] <= t_bz1[CUBE_W-1:2*FRAC_W];
      bz4_q[2] <= t_bz2[CUBE_W-1:2*FRAC_W];
      bz4_q[3] <= t_bz3[CUBE_W-1:2*FRAC_W];
      a4_q <= t_a[FRAC_W+A_W-1:FRAC_W];
      b4_q <= t_b[FRAC_W+A_W-1:FRAC_W];
      h4_q <= t_h[CUBE_W-1:2*FRAC_W];
      q4_q[0] <= n0[2*FRAC_W+Q_W-1:2*FRAC_W];
      q4_q[1] <= n1[2*FRAC_W+Q_W-1:2*FRAC_W];
      q4_q[2] <= n2[2*FRAC_W+Q_W-1:2*FRAC_W];
      q4_q[3] <= n3[2*FRAC_W+Q_W-1:2*FRAC_W];
      u4_q <= u3_q;
      v4_q <= v3_q;
      kind4_q <= kind3_q;
    end
  end

  assign s17 = $signed({3'b000, ONE_Q16}) - S_W'($signed(tension_i));

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sa5_q <= SP_W'(s17) * SP_W'($signed({1'b0, a4_q}));
      sb5_q <= SP_W'(s17) * SP_W'($signed({1'b0, b4_q}));
      for (int k = 0; k < 4; k++) begin
        bp5_q[k] <= BP_W'(q4_q[k]) * BP_W'(DIV6_MUL);
      end
      bz5_q <= bz4_q;
      h5_q <= h4_q;
      u5_q <= u4_q;
      v5_q <= v4_q;
      kind5_q <= kind4_q;
    end
  end

  always_comb begin
    ta = sa5_q + RND_33;
    tb = sb5_q + RND_33;
    sa_w = WGT_W'($signed(ta[SP_W-1:33]));
    sb_w = WGT_W'($signed(tb[SP_W-1:33]));
    h_w = $signed({3'b000, h5_q});
    case (kind5_q)
      KIND_LINEAR: begin
        w6_d[0] = $signed({3'b000, v5_q});
        w6_d[1] = $signed({3'b000, u5_q});
        w6_d[2] = '0;
        w6_d[3] = '0;
      end
      KIND_BEZIER: begin
        for (int k = 0; k < 4; k++) begin
          w6_d[k] = $signed({3'b000, bz5_q[k]});
        end
      end
      KIND_CATMULL: begin
        w6_d[0] = -sa_w;
        w6_d[1] = ONE_W - h_w + sb_w;
        w6_d[2] = h_w + sa_w;
        w6_d[3] = -sb_w;
      end
      default: begin
        // Quotient by six through the reciprocal, exact for these ranges.
        for (int k = 0; k < 4; k++) begin
          w6_d[k] = $signed({3'b000, bp5_q[k][BP_W-1:20]});
        end
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      w6_q <= w6_d;
      kind6_q <= kind5_q;
    end
  end

  assign w_o = w6_q;
  assign kind_o = kind6_q;
endmodule

`default_nettype wire

// ----- design/spe_blend.sv -----
// Control point selection and weighted sum: forms the four points from the
// store reads, multiplies by the weights and rounds. Depends on spe_pkg.
`default_nettype none

module spe_blend
  import spe_pkg::*;
(
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [KIND_W-1:0] kind_i,
  input  logic              zero_i,
  input  vec3_t [3:0]       pos_i,
  input  vec3_t             tin_i,
  input  vec3_t             tout_i,
  input  wgt_t [3:0]        w_i,
  output vec3_t             res_o
);
  localparam logic signed [SUM_W-1:0] RND_16 = SUM_W'(1) << 15;

  logic [KIND_W-1:0] kind2_q;
  logic [7:2]        zero_q;
  vec3_t [3:0]       pt3_d, pt3_q, pt4_q, pt5_q, pt6_q;
  logic [3:0][2:0][PROD_W-1:0] prod_d, prod7_q;
  logic signed [SUM_W-1:0] acc [3];
  vec3_t             res_d, res_q;

  always_comb begin
    pt3_d = pos_i;
    case (kind2_q)
      KIND_LINEAR: begin
        pt3_d[0] = pos_i[1];
        pt3_d[1] = pos_i[2];
      end
      KIND_BEZIER: begin
        pt3_d[0] = pos_i[1];
        pt3_d[3] = pos_i[2];
        for (int c = 0; c < 3; c++) begin
          pt3_d[1][c] = pos_i[1][c] + tout_i[c];
          pt3_d[2][c] = pos_i[2][c] + tin_i[c];
        end
      end
      default: begin
        pt3_d = pos_i;
      end
    endcase
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      for (int c = 0; c < 3; c++) begin
        prod_d[k][c] = PROD_W'($signed(pt6_q[k][c])) * PROD_W'($signed(w_i[k]));
      end
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      acc[c] = SUM_W'($signed(prod7_q[0][c])) + SUM_W'($signed(prod7_q[1][c]))
             + SUM_W'($signed(prod7_q[2][c])) + SUM_W'($signed(prod7_q[3][c]))
             + RND_16;
      res_d[c] = zero_q[7] ? '0 : acc[c][FRAC_W+COORD_W-1:FRAC_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      kind2_q <= kind_i;
      zero_q <= {zero_q[6:2], zero_i};
      pt3_q <= pt3_d;
      pt4_q <= pt3_q;
      pt5_q <= pt4_q;
      pt6_q <= pt5_q;
      prod7_q <= prod_d;
      res_q <= res_d;
    end
  end

  assign res_o = res_q;
endmodule

`default_nettype wire

// ----- design/cubic_spline_point_evaluator.sv -----
// Cubic spline point evaluator, top level.
// Instantiates spe_seg, spe_weights, spe_blend and spe_ram; uses spe_pkg.
//
// Usage: configuration registers (curve kind, closed loop, tension, point
// count) are written through cfg_we_i/cfg_idx_i/cfg_data_i while the block
// is idle. Command transactions enter on in_i: ops 0 to 2 store a position,
// incoming tangent or outgoing tangent for one control point and give no
// result; op 3 evaluates the curve at eval_param and gives one transaction
// on out_o with the point in Q16.16.
// One command is taken every cycle unless out_o is stalled; the whole
// pipeline advances together and its store reads are registered into
// stage 2. When out_o is stalled the whole pipeline holds and in_i.ready
// drops; nothing is lost or repeated. Reset clears the configuration to
// zero and empties the pipeline. Point stores are not cleared by reset.
`default_nettype none

module cubic_spline_point_evaluator
  import spe_pkg::*;
#(
  parameter int MAX_POINTS = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  spe_in_if.sink                in_i,
  spe_out_if.source             out_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);
  localparam int IDX_W = $clog2(MAX_POINTS);
  localparam int VEC_W = 3 * COORD_W;

  cfg_t cfg_q;
  logic en;

  logic               p0_vld_q, p1_vld_q;
  logic [OP_W-1:0]    p0_op_q, p1_op_q;
  logic [PIDX_W-1:0]  p0_idx_q, p1_idx_q;
  vec3_t              p0_vec_q, p1_vec_q;
  logic [PARAM_W-1:0] p0_param_q;
  logic [8:2]         ev_q;

  logic [PARAM_W-1:0]      seg_u;
  logic [KIND_W-1:0]       seg_kind, w_kind;
  logic                    seg_zero;
  logic [CNT_W-1:0]        seg_n;
  logic [3:0][IDX_W-1:0]   seg_idx;
  wgt_t [3:0]              w;
  vec3_t [3:0]             pos_rd;
  vec3_t                   tin_rd, tout_rd, res;
  logic                    wr_ok, pos_we, tin_we, tout_we;
  logic [IDX_W-1:0]        waddr;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_KIND:    cfg_q.kind <= cfg_data_i[KIND_W-1:0];
        CFG_CLOSED:  cfg_q.closed <= cfg_data_i[0];
        CFG_TENSION: cfg_q.tension <= cfg_data_i[TENS_W-1:0];
        CFG_COUNT:   cfg_q.count <= cfg_data_i[CNT_W-1:0];
        default:     cfg_q <= cfg_q;
      endcase
    end
  end

  // The pipeline advances as a whole whenever the output register can move.
  assign en = !ev_q[8] || out_o.ready;
  assign in_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p0_vld_q <= 1'b0;
      p1_vld_q <= 1'b0;
      ev_q <= '0;
    end else if (en) begin
      p0_vld_q <= in_i.valid;
      p1_vld_q <= p0_vld_q;
      ev_q <= {ev_q[7:2], p1_vld_q && (p1_op_q == OP_EVAL)};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p0_op_q <= in_i.op;
      p0_idx_q <= in_i.point_index;
      p0_vec_q[0] <= in_i.vec_x;
      p0_vec_q[1] <= in_i.vec_y;
      p0_vec_q[2] <= in_i.vec_z;
      p0_param_q <= in_i.eval_param;
      p1_op_q <= p0_op_q;
      p1_idx_q <= p0_idx_q;
      p1_vec_q <= p0_vec_q;
    end
  end

  spe_seg #(
    .MAX_POINTS (MAX_POINTS)
  ) u_seg (
    .clk_i   (clk_i),
    .en_i    (en),
    .cfg_i   (cfg_q),
    .param_i (p0_param_q),
    .u_o     (seg_u),
    .kind_o  (seg_kind),
    .zero_o  (seg_zero),
    .n_o     (seg_n),
    .idx_o   (seg_idx)
  );

  // Stores are written in the same stage in which evaluations read them, so
  // every transaction sees exactly the writes accepted before it.
  assign wr_ok = en && p1_vld_q && (p1_op_q != OP_EVAL) && (int'(p1_idx_q) < MAX_POINTS);
  assign pos_we = wr_ok && (p1_op_q == OP_WR_POS);
  assign tin_we = wr_ok && (p1_op_q == OP_WR_TIN);
  assign tout_we = wr_ok && (p1_op_q == OP_WR_TOUT);
  assign waddr = IDX_W'(p1_idx_q);

  for (genvar k = 0; k < 4; k++) begin : g_pos
    spe_ram #(
      .WIDTH (VEC_W),
      .DEPTH (MAX_POINTS)
    ) u_pos_ram (
      .clk_i   (clk_i),
      .we_i    (pos_we),
      .waddr_i (waddr),
      .wdata_i (p1_vec_q),
      .re_i    (en),
      .raddr_i (seg_idx[k]),
      .rdata_o (pos_rd[k])
    );
  end

  spe_ram #(
    .WIDTH (VEC_W),
    .DEPTH (MAX_POINTS)
  ) u_tin_ram (
    .clk_i   (clk_i),
    .we_i    (tin_we),
    .waddr_i (waddr),
    .wdata_i (p1_vec_q),
    .re_i    (en),
    .raddr_i (seg_idx[2]),
    .rdata_o (tin_rd)
  );

  spe_ram #(
    .WIDTH (VEC_W),
    .DEPTH (MAX_POINTS)
  ) u_tout_ram (
    .clk_i   (clk_i),
    .we_i    (tout_we),
    .waddr_i (waddr),
    .wdata_i (p1_vec_q),
    .re_i    (en),
    .raddr_i (seg_idx[1]),
    .rdata_o (tout_rd)
  );

  spe_weights u_weights (
    .clk_i     (clk_i),
    .en_i      (en),
    .u_i       (seg_u),
    .kind_i    (seg_kind),
    .tension_i (cfg_q.tension),
    .w_o       (w),
    .kind_o    (w_kind)
  );

  spe_blend u_blend (
    .clk_i  (clk_i),
    .en_i   (en),
    .kind_i (seg_kind),
    .zero_i (seg_zero),
    .pos_i  (pos_rd),
    .tin_i  (tin_rd),
    .tout_i (tout_rd),
    .w_i    (w),
    .res_o  (res)
  );

  assign out_o.valid = ev_q[8];
  assign out_o.curve_x = res[0];
  assign out_o.curve_y = res[1];
  assign out_o.curve_z = res[2];

`ifndef SYNTHESIS
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(ev_q))
    else $error("pipeline valid bits moved during a stall");

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    p1_vld_q && (p1_op_q == OP_EVAL) && (seg_n >= CNT_W'(2)) |->
      (int'(seg_idx[0]) < int'(seg_n)) && (int'(seg_idx[1]) < int'(seg_n)) &&
      (int'(seg_idx[2]) < int'(seg_n)) && (int'(seg_idx[3]) < int'(seg_n)))
    else $error("neighbor index outside the points in use");

  a_wsum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ev_q[6] && ((w_kind == KIND_LINEAR) || (w_kind == KIND_CATMULL)) |->
      (int'(w[0]) + int'(w[1]) + int'(w[2]) + int'(w[3])) == 65536)
    else $error("basis weights do not sum to one");
`endif

endmodule

`default_nettype wire
